### src/shdp_pkg.sv
// Package for the sample histogram delta packer.
// Holds widths, reset values, command codes and the sequencer state type.
// Used by sample_histogram_delta_packer_unit.
`timescale 1ns / 1ps
`default_nettype none

package shdp_pkg;

  // Defaults for the top level parameters.
  localparam int unsigned MAX_OBS_DEF    = 4096;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int unsigned OBS_CNT_W = 13;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned DELTA_W   = 12;
  localparam int unsigned OUT_CNT_W = 16;

  localparam logic [OBS_CNT_W-1:0] OBS_COUNT_RST = 13'd4096;

  // Command codes.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_SCAN_RD,
    ST_SCAN_CHK
  } state_e;

endpackage

`default_nettype wire

### src/shdp_count_ram.sv
// Single-port count store with a registered read port.
// Depth and widths come from the top level parameters; no package use.
`timescale 1ns / 1ps
`default_nettype none

module shdp_count_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/sample_histogram_delta_packer_unit.sv
// Sample histogram delta packer, top level. Uses shdp_pkg and shdp_count_ram.
// After reset the count store is cleared entry by entry with busy high.
// An add keeps busy high through a read and a write state after its accept edge, an ignored
// add not at all; a fetch through a registered read and a check per entry examined, plus a
// last read when it reaches the limit and answers done. The result strobe comes in the cycle
// busy falls. Reset is asynchronous; the receiver cannot stall, so results are never held.
`timescale 1ns / 1ps
`default_nettype none

module sample_histogram_delta_packer_unit #(
  parameter int unsigned MAX_OBS    = shdp_pkg::MAX_OBS_DEF,
  parameter int unsigned COUNT_BITS = shdp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [shdp_pkg::OBS_CNT_W-1:0]   cfg_wdata_i,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             cmd_i,
  input  wire logic [shdp_pkg::IDX_W-1:0]       obs_index_i,
  output logic                                  result_valid_o,
  output logic      [shdp_pkg::DELTA_W-1:0]     row_delta_o,
  output logic      [shdp_pkg::OUT_CNT_W-1:0]   sample_count_o,
  output logic                                  done_res_o
);

  localparam int unsigned PW = shdp_pkg::OBS_CNT_W;
  localparam int unsigned AW = (MAX_OBS > 1) ? $clog2(MAX_OBS) : 1;
  localparam bit          CAPPED = MAX_OBS < (2 ** PW);
  localparam logic [PW-1:0] MAX_LIM = CAPPED ? PW'(MAX_OBS) : '1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_OBS - 1);

  shdp_pkg::state_e state_q, state_d;

  logic [PW-1:0]         obs_count_q;
  logic [PW-1:0]         pos_q, pos_d;
  logic [PW-1:0]         last_q, last_d;
  logic [PW-1:0]         addr_q, addr_d;
  logic [AW-1:0]         clr_q, clr_d;
  logic                  res_valid_q, res_valid_d;
  logic [shdp_pkg::DELTA_W-1:0]   row_delta_q, row_delta_d;
  logic [shdp_pkg::OUT_CNT_W-1:0] sample_count_q, sample_count_d;
  logic                  done_q, done_d;

  logic [PW-1:0]         lim;
  logic                  accept;
  logic                  add_in_range;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [COUNT_BITS-1:0] mem_wdata, mem_rdata;

  // Adds and the scan only cover indices below min(obs_count, MAX_OBS).
  assign lim          = (obs_count_q > MAX_LIM) ? MAX_LIM : obs_count_q;
  assign busy         = (state_q != shdp_pkg::ST_IDLE);
  assign accept       = start && !busy;
  assign add_in_range = ({1'b0, obs_index_i} < lim);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obs_count_q <= shdp_pkg::OBS_COUNT_RST;
    end else if (cfg_we_i) begin
      obs_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      shdp_pkg::ST_CLEAR: begin
        if (clr_q == CLR_LAST) state_d = shdp_pkg::ST_IDLE;
      end
      shdp_pkg::ST_IDLE: begin
        if (accept) begin
          if (cmd_i == shdp_pkg::CMD_FETCH) begin
            state_d = shdp_pkg::ST_SCAN_RD;
          end else if (add_in_range) begin
            state_d = shdp_pkg::ST_ADD_RD;
          end
        end
      end
      shdp_pkg::ST_ADD_RD:  state_d = shdp_pkg::ST_ADD_WR;
      shdp_pkg::ST_ADD_WR:  state_d = shdp_pkg::ST_IDLE;
      shdp_pkg::ST_SCAN_RD: begin
        state_d = (pos_q < lim) ? shdp_pkg::ST_SCAN_CHK : shdp_pkg::ST_IDLE;
      end
      shdp_pkg::ST_SCAN_CHK: begin
        state_d = (mem_rdata != '0) ? shdp_pkg::ST_IDLE : shdp_pkg::ST_SCAN_RD;
      end
      default: state_d = shdp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_addr       = AW'(addr_q);
    mem_wdata      = '0;
    pos_d          = pos_q;
    last_d         = last_q;
    addr_d         = addr_q;
    clr_d          = clr_q;
    res_valid_d    = 1'b0;
    row_delta_d    = row_delta_q;
    sample_count_d = sample_count_q;
    done_d         = done_q;
    case (state_q)
      shdp_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + 1'b1;
      end
      shdp_pkg::ST_IDLE: begin
        addr_d = {1'b0, obs_index_i};
      end
      shdp_pkg::ST_ADD_RD: begin
        mem_re = 1'b1;
      end
      shdp_pkg::ST_ADD_WR: begin
        mem_we = 1'b1;
        // Saturate at the top count.
        mem_wdata = (&mem_rdata) ? mem_rdata : mem_rdata + 1'b1;
      end
      shdp_pkg::ST_SCAN_RD: begin
        mem_addr = AW'(pos_q);
        if (pos_q < lim) begin
          mem_re = 1'b1;
        end else begin
          // Nothing left in this pass: answer done and rewind.
          pos_d          = '0;
          last_d         = '0;
          res_valid_d    = 1'b1;
          row_delta_d    = '0;
          sample_count_d = '0;
          done_d         = 1'b1;
        end
      end
      shdp_pkg::ST_SCAN_CHK: begin
        mem_addr = AW'(pos_q);
        pos_d    = pos_q + 1'b1;
        if (mem_rdata != '0) begin
          mem_we         = 1'b1;
          last_d         = pos_q;
          res_valid_d    = 1'b1;
          row_delta_d    = shdp_pkg::DELTA_W'(pos_q - last_q);
          sample_count_d = shdp_pkg::OUT_CNT_W'(mem_rdata);
          done_d         = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shdp_pkg::ST_CLEAR;
      pos_q       <= '0;
      last_q      <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q         <= addr_d;
    row_delta_q    <= row_delta_d;
    sample_count_q <= sample_count_d;
    done_q         <= done_d;
  end

  shdp_count_ram #(
    .DEPTH (MAX_OBS),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign result_valid_o = res_valid_q;
  assign row_delta_o    = row_delta_q;
  assign sample_count_o = sample_count_q;
  assign done_res_o     = done_q;

  // A result beat is only shown while the sequencer is back at rest.
  a_result_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result beat while busy");

  // Each fetch yields one beat, so beats never come back to back.
  a_no_double_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("two result beats in a row");

  // The done marker carries zero payload.
  a_done_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && done_res_o) |-> (row_delta_o == '0 && sample_count_o == '0))
    else $error("done beat with nonzero payload");

  // An add never produces a result beat.
  a_add_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd_i == shdp_pkg::CMD_ADD) |=> !result_valid_o ##1 !result_valid_o)
    else $error("result beat after an add");

endmodule

`default_nettype wire
